>>> hdl/mfdl_pkg.sv
// Shared widths, register map, state encoding and saturation and rounding helpers for the delay line.
package mfdl_pkg;

    // Field widths
    localparam int SMP_W  = 24;
    localparam int LFO_W  = 16;
    localparam int BASE_W = 18;
    localparam int DEP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int FB_W   = 16;
    localparam int MIX_W  = 17;
    // Modulated delay before wrap: base (18 b) * factor (< 2^32) >> 31
    localparam int DLY_W  = 19;
    localparam int FACT_W = 32;
    // Width of products and sums ahead of rounding
    localparam int ACC_W  = 50;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_BASE_DELAY = 3'd0;
    localparam logic [2:0] REG_MOD_DEPTH  = 3'd1;
    localparam logic [2:0] REG_INPUT_GAIN = 3'd2;
    localparam logic [2:0] REG_FEEDBACK   = 3'd3;
    localparam logic [2:0] REG_MIX        = 3'd4;
    localparam logic [2:0] REG_MODE       = 3'd5;

    // Register reset values
    localparam logic [BASE_W-1:0] RST_BASE_DELAY = 18'd14400;
    localparam logic [DEP_W-1:0]  RST_MOD_DEPTH  = 16'd177;
    localparam logic [GAIN_W-1:0] RST_INPUT_GAIN = 16'd4096;
    localparam logic [FB_W-1:0]   RST_FEEDBACK   = 16'd6554;
    localparam logic [MIX_W-1:0]  RST_MIX        = 17'd32768;

    // Unity in Q1.16 for the mix, unity in Q1.31 for the modulation factor
    localparam logic [MIX_W-1:0]         MIX_ONE    = 17'd65536;
    localparam logic signed [FACT_W+1:0] FACT_ONE   = 34'sd2147483648;

    localparam logic signed [ACC_W-1:0]  SAT_HI = 50'sd8388607;
    localparam logic signed [ACC_W-1:0]  SAT_LO = -50'sd8388608;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_FACT  = 12'b0000_0000_0100,
        S_DPROD = 12'b0000_0000_1000,
        S_MOD   = 12'b0000_0001_0000,
        S_ADDR  = 12'b0000_0010_0000,
        S_ADDR2 = 12'b0000_0100_0000,
        S_READ  = 12'b0000_1000_0000,
        S_WRIN  = 12'b0001_0000_0000,
        S_RDFB  = 12'b0010_0000_0000,
        S_FBW   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    // Clamp to the Q1.23 range
    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SMP_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

    // Round to nearest, ties toward plus infinity, then arithmetic shift right
    function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v,
                                                         input int n);
        logic signed [ACC_W-1:0] t;
        t = v + (ACC_W'(1) << (n - 1));
        return t >>> n;
    endfunction

endpackage

>>> hdl/mfdl_ram.sv
// Generic single-port RAM with registered read data.
module mfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, read-before-write on the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/modulated_feedback_delay_line_unit.sv
// Modulated feedback delay line with stereo ping-pong mode: control, datapath and ring store.
//
// One item is one Q1.23 sample for one channel plus the current Q1.15 oscillator value; it
// yields one dry/wet mixed Q1.23 sample. All ring state sits in one single-port RAM of
// CHANNELS*RING_DEPTH words, so an item takes four RAM accesses (delayed read, input write,
// feedback read, feedback write) behind a short arithmetic sequence. The states run S_FACT,
// S_DPROD, S_MOD (once per quotient bit, MOD_STEPS = 19 - floor(log2(RING_DEPTH)) of them,
// at least 1), S_ADDR, S_ADDR2, S_READ, S_WRIN, S_RDFB, S_FBW and S_OUT, which registers the
// result and waits while the output is stalled; a new item is taken only once the last one is
// through. The wrap of the modulated delay into the ring is the iterative part, one
// compare-subtract per cycle. s_axis_tready is high only between items; a finished result
// waits in the output register while the next item is taken. After reset the RAM is cleared
// one word a cycle, all CHANNELS*RING_DEPTH words (524288 at the defaults), during which no
// item is taken; configuration writes are taken at all times.
module modulated_feedback_delay_line_unit
    import mfdl_pkg::*;
#(
    parameter int RING_DEPTH = 262144,
    parameter int CHANNELS   = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [23:0] sample_in, [39:24] lfo_value
    input  logic [0:0]  s_axis_tuser,   // [0] channel
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] sample_out
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW        = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = RING_DEPTH * CHANNELS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int LOG2R     = $clog2(RING_DEPTH + 1) - 1;
    localparam int MOD_STEPS = (DLY_W > LOG2R) ? (DLY_W - LOG2R) : 1;
    localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int MODW      = DLY_W + MOD_STEPS + 2;

    // Configuration registers
    logic [BASE_W-1:0] r_base;
    logic [DEP_W-1:0]  r_depth;
    logic [GAIN_W-1:0] r_gain;
    logic [FB_W-1:0]   r_fbk;
    logic [MIX_W-1:0]  r_mix;
    logic              r_mode;

    // Control state
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic [RW-1:0]     r_pos;
    logic [KW-1:0]     r_k;
    logic              r_out_vld;

    // Datapath registers
    logic signed [SMP_W-1:0] r_dry;
    logic signed [LFO_W-1:0] r_lfo;
    logic                    r_ch;
    logic [FACT_W-1:0]       r_factor;
    logic [DLY_W-1:0]        r_rem;
    logic [RW-1:0]           r_half;
    logic [RW-1:0]           r_rd_a;
    logic [RW-1:0]           r_fb_a;
    logic [RW-1:0]           r_rd;
    logic [RW-1:0]           r_fbs;
    logic signed [ACC_W-1:0] r_gprod;
    logic signed [SMP_W-1:0] r_gained;
    logic signed [ACC_W-1:0] r_dprod;
    logic signed [SMP_W-1:0] r_now;
    logic signed [ACC_W-1:0] r_fbprod;
    logic signed [ACC_W-1:0] r_wprod;
    logic signed [SMP_W-1:0] r_out;

    // RAM port
    logic              w_we;
    logic [AW-1:0]     w_addr;
    logic [SMP_W-1:0]  w_wdata;
    logic [SMP_W-1:0]  w_rdata;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic                      w_cfg_wr;
    logic                      w_ch;
    logic [RW-1:0]             w_pos_nxt;
    logic signed [32:0]        w_lprod;
    logic signed [FACT_W+1:0]  w_fsum;
    logic [BASE_W+FACT_W-1:0]  w_dfull;
    logic [DLY_W-1:0]          w_dly;
    logic [MODW-1:0]           w_cmp;
    logic [RW-1:0]             w_d;
    logic [RW:0]               w_d1;
    logic                      w_odd_pp;
    logic [MIX_W-1:0]          w_wet;
    logic [MIX_W-1:0]          w_dry_w;
    logic signed [40:0]        w_gmul;
    logic signed [41:0]        w_dmul;
    logic signed [41:0]        w_wmul;
    logic signed [40:0]        w_fmul;
    logic signed [SMP_W-1:0]   w_fbval;
    logic signed [SMP_W-1:0]   w_fbnew;

    // (a - b) mod RING_DEPTH for a, b below RING_DEPTH
    function automatic logic [RW-1:0] sub_mod(input logic [RW-1:0] a, input logic [RW-1:0] b);
        logic [RW:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + (RW+1)'(RING_DEPTH) - {1'b0, b};
        end
        return t[RW-1:0];
    endfunction

    // Channel row plus slot gives the RAM word
    function automatic logic [AW-1:0] row_addr(input logic row, input logic [RW-1:0] slot);
        logic [AW-1:0] a;
        if (row) begin
            a = AW'(RING_DEPTH) + AW'(slot);
        end else begin
            a = AW'(slot);
        end
        return a;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_acc     = r_out_vld & m_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE_DELAY;
            r_depth <= RST_MOD_DEPTH;
            r_gain  <= RST_INPUT_GAIN;
            r_fbk   <= RST_FEEDBACK;
            r_mix   <= RST_MIX;
            r_mode  <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_BASE_DELAY: r_base  <= pwdata[BASE_W-1:0];
                REG_MOD_DEPTH:  r_depth <= pwdata[DEP_W-1:0];
                REG_INPUT_GAIN: r_gain  <= pwdata[GAIN_W-1:0];
                REG_FEEDBACK:   r_fbk   <= pwdata[FB_W-1:0];
                REG_MIX:        r_mix   <= pwdata[MIX_W-1:0];
                REG_MODE:       r_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_BASE_DELAY: prdata = 32'(r_base);
            REG_MOD_DEPTH:  prdata = 32'(r_depth);
            REG_INPUT_GAIN: prdata = 32'(r_gain);
            REG_FEEDBACK:   prdata = 32'(r_fbk);
            REG_MIX:        prdata = 32'(r_mix);
            REG_MODE:       prdata = 32'(r_mode);
            default:        prdata = '0;
        endcase
    end

    // Arithmetic terms
    assign w_ch      = (CHANNELS > 1) ? s_axis_tuser[0] : 1'b0;
    assign w_pos_nxt = (r_pos == RW'(RING_DEPTH - 1)) ? '0 : r_pos + RW'(1);
    assign w_lprod   = r_lfo * $signed({1'b0, r_depth});
    assign w_fsum    = FACT_ONE + {w_lprod[32], w_lprod};
    assign w_dfull   = r_base * r_factor;
    assign w_dly     = (w_dfull[BASE_W+FACT_W-1:31] == '0) ? DLY_W'(1)
                                                           : w_dfull[BASE_W+FACT_W-1:31];
    assign w_cmp     = MODW'(RING_DEPTH) << r_k;
    assign w_d       = RW'(r_rem);
    assign w_d1      = {1'b0, w_d} + (RW+1)'(1);
    assign w_odd_pp  = r_mode & r_ch;
    assign w_wet     = (r_mix > MIX_ONE) ? MIX_ONE : r_mix;
    assign w_dry_w   = MIX_ONE - w_wet;
    assign w_gmul    = r_dry * $signed({1'b0, r_gain});
    assign w_dmul    = r_dry * $signed({1'b0, w_dry_w});
    assign w_wmul    = r_now * $signed({1'b0, w_wet});
    assign w_fmul    = r_now * $signed({1'b0, r_fbk});
    assign w_fbval   = (r_fbs == r_pos) ? r_gained : $signed(w_rdata);
    assign w_fbnew   = sat24(ACC_W'(w_fbval) + rnd_shr(r_fbprod, 16));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(MEM_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_in_acc) n_state = S_FACT;
            S_FACT:  n_state = S_DPROD;
            S_DPROD: n_state = S_MOD;
            S_MOD:   if (r_k == '0) n_state = S_ADDR;
            S_ADDR:  n_state = S_ADDR2;
            S_ADDR2: n_state = S_READ;
            S_READ:  n_state = S_WRIN;
            S_WRIN:  n_state = S_RDFB;
            S_RDFB:  n_state = S_FBW;
            S_FBW:   n_state = S_OUT;
            S_OUT:   if (!r_out_vld || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pos     <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_in_acc && !w_ch) begin
                r_pos <= w_pos_nxt;
            end
            if (r_state == S_DPROD) begin
                r_k <= KW'(MOD_STEPS - 1);
            end else if (r_state == S_MOD && r_k != '0) begin
                r_k <= r_k - KW'(1);
            end
            // A new result replaces the one taken in the same cycle
            if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dry <= $signed(s_axis_tdata[23:0]);
            r_lfo <= $signed(s_axis_tdata[39:24]);
            r_ch  <= w_ch;
        end
        if (r_state == S_FACT) begin
            r_factor <= w_fsum[FACT_W-1:0];
        end
        // Delay, then wrap into the ring one quotient bit a cycle
        if (r_state == S_DPROD) begin
            r_rem <= w_dly;
        end else if (r_state == S_MOD && MODW'(r_rem) >= w_cmp) begin
            r_rem <= r_rem - w_cmp[DLY_W-1:0];
        end
        // Slot arithmetic, first half
        if (r_state == S_ADDR) begin
            r_half  <= w_d1[RW:1];
            r_rd_a  <= sub_mod(r_pos, w_d);
            r_fb_a  <= r_mode ? sub_mod(r_pos, RW'(1)) : r_pos;
            r_gprod <= ACC_W'(w_gmul);
        end
        // Odd channel in ping-pong mode steps back another half delay
        if (r_state == S_ADDR2) begin
            r_rd     <= w_odd_pp ? sub_mod(r_rd_a, r_half) : r_rd_a;
            r_fbs    <= w_odd_pp ? sub_mod(r_fb_a, r_half) : r_fb_a;
            r_gained <= sat24(rnd_shr(r_gprod, 12));
            r_dprod  <= ACC_W'(w_dmul);
        end
        if (r_state == S_WRIN) begin
            r_now <= $signed(w_rdata);
        end
        if (r_state == S_RDFB) begin
            r_fbprod <= ACC_W'(w_fmul);
        end
        if (r_state == S_FBW) begin
            r_wprod <= ACC_W'(w_wmul);
        end
        if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
            r_out <= sat24(rnd_shr(r_dprod + r_wprod, 16));
        end
    end

    // RAM access per state
    always_comb begin
        w_we    = 1'b0;
        w_addr  = row_addr(r_ch, r_rd);
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr;
            end
            S_READ: begin
                w_addr = row_addr(r_ch, r_rd);
            end
            S_WRIN: begin
                w_we    = 1'b1;
                w_addr  = row_addr(r_ch, r_pos);
                w_wdata = r_gained;
            end
            S_RDFB: begin
                w_addr = row_addr(r_ch, r_fbs);
            end
            S_FBW: begin
                w_we    = 1'b1;
                w_addr  = row_addr(r_ch, r_fbs);
                w_wdata = w_fbnew;
            end
            default: ;
        endcase
    end

    mfdl_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MEM_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < (RW+1)'(RING_DEPTH))
        else $error("write position outside ring");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_FACT))
        else $error("accepted item did not start processing");

    a_slots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_rd} < (RW+1)'(RING_DEPTH)
                                 && {1'b0, r_fbs} < (RW+1)'(RING_DEPTH)))
        else $error("ring slot outside ring");

    a_pp_fb_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FBW && r_mode) |-> (r_fbs != r_pos))
        else $error("ping-pong feedback slot hit write slot");

endmodule

>>> sim/modulated_feedback_delay_line_unit_tb.sv
// Self-checking testbench for the modulated feedback delay line unit.
`timescale 1ns / 1ps

module modulated_feedback_delay_line_unit_tb;
    import mfdl_pkg::*;

    localparam int RING        = 262144;
    localparam int CHANS       = 2;
    localparam int LATENCY     = 10;
    localparam int SETTLE      = LATENCY + 5;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 175;
    localparam int HOLD_CYCLES = 400;

    // Register slots outside the map; writes there must not land anywhere
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [23:0] sample_in, [39:24] lfo_value
    logic [0:0]  s_axis_tuser;   // [0] channel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [23:0] sample_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // One row of the directed plan: a register write or an item
    typedef struct {
        logic                    is_cfg;
        logic [2:0]              reg_idx;
        logic [31:0]             reg_val;
        logic signed [SMP_W-1:0] smp;
        logic                    ch;
        logic signed [LFO_W-1:0] lfo;
        logic                    typed;
        logic signed [SMP_W-1:0] want;
    } t_plan_row;

    // Shadow of the block's registers and ring state
    logic [BASE_W-1:0] base_cfg  = RST_BASE_DELAY;
    logic [DEP_W-1:0]  depth_cfg = RST_MOD_DEPTH;
    logic [GAIN_W-1:0] gain_cfg  = RST_INPUT_GAIN;
    logic [FB_W-1:0]   fb_cfg    = RST_FEEDBACK;
    logic [MIX_W-1:0]  mix_cfg   = RST_MIX;
    logic              mode_cfg  = 1'b0;
    bit signed [SMP_W-1:0] ring_img [CHANS][RING];
    longint            wr_pos    = 0;

    logic signed [SMP_W-1:0] mix_due [$];

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    bit  hold_req     = 1'b0;
    bit  gaps_on      = 1'b1;

    modulated_feedback_delay_line_unit #(
        .RING_DEPTH(RING),
        .CHANNELS  (CHANS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp to Q1.23
    function automatic logic signed [SMP_W-1:0] clamp24(input longint v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[SMP_W-1:0];
    endfunction

    // Rounding right shift, ties toward plus infinity
    function automatic longint round_off(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // Advance the shadow ring by one item and return the mixed output sample
    function automatic logic signed [SMP_W-1:0] predict_mix(
            input logic signed [SMP_W-1:0] dry, input logic ch,
            input logic signed [LFO_W-1:0] lfo);
        logic signed [SMP_W-1:0] gained;
        longint tap, fb_term, acc, factor, dly, half, back, rd, fb_slot, pos, wet;
        gained = clamp24(round_off(longint'(dry) * longint'(gain_cfg), 12));
        if (ch == 1'b0) begin
            wr_pos = (wr_pos + 1) % RING;
        end
        pos = wr_pos;

        // Modulated delay, wrapped into the ring
        factor = 64'sd2147483648 + longint'(lfo) * longint'(depth_cfg);
        dly    = (longint'(base_cfg) * factor) >>> 31;
        if (dly < 1) begin
            dly = 1;
        end
        dly  = dly % RING;
        half = (dly + 1) >>> 1;
        back = (mode_cfg && ch) ? dly + half : dly;
        rd   = (pos + 3 * RING - back) % RING;

        // Feedback lands at the write slot, or at the ping-pong offset
        if (!mode_cfg) begin
            fb_slot = pos;
        end else if (ch) begin
            fb_slot = (pos + 3 * RING - 1 - half) % RING;
        end else begin
            fb_slot = (pos + 3 * RING - 1) % RING;
        end

        tap = ring_img[ch][rd];
        ring_img[ch][pos] = gained;
        fb_term = round_off(tap * longint'(fb_cfg), 16);
        ring_img[ch][fb_slot] = clamp24(longint'(ring_img[ch][fb_slot]) + fb_term);

        wet = (mix_cfg > MIX_ONE) ? 64'sd65536 : longint'(mix_cfg);
        acc = longint'(dry) * (64'sd65536 - wet) + tap * wet;
        return clamp24(round_off(acc, 16));
    endfunction

    function automatic t_plan_row cfg_row(input logic [2:0] idx, input logic [31:0] val);
        t_plan_row r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_plan_row item_row(input logic signed [SMP_W-1:0] smp, input logic ch,
                                           input logic signed [LFO_W-1:0] lfo,
                                           input logic typed,
                                           input logic signed [SMP_W-1:0] want);
        t_plan_row r;
        r       = '{default: '0};
        r.smp   = smp;
        r.ch    = ch;
        r.lfo   = lfo;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(19))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'sh000000;
            3:       return 24'shFFFFFF;
            4:       return 24'($signed($urandom_range(2048)) - 1024);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [LFO_W-1:0] pick_lfo();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Register write with setup and access phases; the shadow follows once the access completes
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_DELAY: base_cfg  = val[BASE_W-1:0];
            REG_MOD_DEPTH:  depth_cfg = val[DEP_W-1:0];
            REG_INPUT_GAIN: gain_cfg  = val[GAIN_W-1:0];
            REG_FEEDBACK:   fb_cfg    = val[FB_W-1:0];
            REG_MIX:        mix_cfg   = val[MIX_W-1:0];
            REG_MODE:       mode_cfg  = val[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    // Offer one item until taken, then queue its expected output
    task automatic push_item(input logic signed [SMP_W-1:0] smp, input logic ch,
                             input logic signed [LFO_W-1:0] lfo, input logic typed,
                             input logic signed [SMP_W-1:0] want);
        logic signed [SMP_W-1:0] pred;
        if (gaps_on && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lfo, smp};
        s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_mix(smp, ch, lfo);
        mix_due.push_back(typed ? want : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering, let every queued result drain, then let the block go idle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (mix_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Output side: random back-pressure while gaps are on, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < 20);
            end
        end
    end

    // Compare each taken output item with the oldest expectation
    always @(posedge i_clk) begin : out_check
        logic signed [SMP_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (mix_due.size() == 0) begin
                flag_error($sformatf("unexpected output item %0d: %0d",
                                     results_seen, $signed(m_axis_tdata)));
            end else begin
                want = mix_due.pop_front();
                if (m_axis_tdata !== want) begin
                    flag_error($sformatf("output item %0d: expected %0d, got %0d",
                                         results_seen, want, $signed(m_axis_tdata)));
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, mix_due.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_plan_row   plan [$];
        logic [31:0] wv;
        int unsigned v;
        int unsigned sel;
        logic        ch;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        // Reset defaults, empty ring: output is half the dry sample
        plan.push_back(item_row(24'sh7FFFFF, 1'b0, 16'sh0000, 1'b1, 24'sh400000));
        plan.push_back(item_row(24'sh800000, 1'b1, 16'sh7FFF, 1'b1, 24'shC00000));
        plan.push_back(item_row(24'sh000000, 1'b0, 16'sh8000, 1'b1, 24'sh000000));
        plan.push_back(item_row(24'sh000001, 1'b1, 16'sh0000, 1'b1, 24'sh000001));
        plan.push_back(item_row(24'shFFFFFF, 1'b0, 16'sh0000, 1'b1, 24'sh000000));
        // Fully dry, ping-pong, max gain and feedback: output equals input
        plan.push_back(cfg_row(REG_MIX,        32'd0));
        plan.push_back(cfg_row(REG_MODE,       32'd1));
        plan.push_back(cfg_row(REG_BASE_DELAY, 32'd3));
        plan.push_back(cfg_row(REG_MOD_DEPTH,  32'd0));
        plan.push_back(cfg_row(REG_INPUT_GAIN, 32'd65535));
        plan.push_back(cfg_row(REG_FEEDBACK,   32'd65535));
        plan.push_back(item_row(24'sh7FFFFF, 1'b0, 16'sh7FFF, 1'b1, 24'sh7FFFFF));
        plan.push_back(item_row(24'sh800000, 1'b1, 16'sh8000, 1'b1, 24'sh800000));
        plan.push_back(item_row(24'sh123456, 1'b0, 16'sh0001, 1'b1, 24'sh123456));
        plan.push_back(item_row(24'shD55556, 1'b1, 16'shFFFF, 1'b1, 24'shD55556));
        // Spare slots ignored; mix above unity, zero base, deepest modulation
        plan.push_back(cfg_row(REG_SPARE_A,    32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_SPARE_B,    32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_MIX,        32'd131071));
        plan.push_back(cfg_row(REG_BASE_DELAY, 32'd0));
        plan.push_back(cfg_row(REG_MOD_DEPTH,  32'd65535));
        plan.push_back(item_row(24'sh400000, 1'b0, 16'sh8000, 1'b0, '0));
        plan.push_back(item_row(24'shC00000, 1'b1, 16'sh7FFF, 1'b0, '0));
        plan.push_back(item_row(24'sh7FFFFF, 1'b0, 16'sh0000, 1'b0, '0));
        plan.push_back(item_row(24'sh000100, 1'b1, 16'sh8000, 1'b0, '0));
        plan.push_back(item_row(24'sh800000, 1'b0, 16'sh7FFF, 1'b0, '0));
        // Delay that wraps to a whole ring: read hits the write slot
        plan.push_back(cfg_row(REG_BASE_DELAY, 32'd262143));
        plan.push_back(cfg_row(REG_MOD_DEPTH,  32'd10000));
        plan.push_back(cfg_row(REG_MODE,       32'd0));
        plan.push_back(cfg_row(REG_MIX,        32'd65536));
        plan.push_back(cfg_row(REG_INPUT_GAIN, 32'd4096));
        plan.push_back(cfg_row(REG_FEEDBACK,   32'd0));
        plan.push_back(item_row(24'sh2468AC, 1'b0, 16'sh0001, 1'b0, '0));
        plan.push_back(item_row(24'shE13579, 1'b1, 16'sh0001, 1'b0, '0));
        plan.push_back(item_row(24'sh0F0F0F, 1'b0, 16'sh8000, 1'b0, '0));
        // Short ping-pong with strong feedback
        plan.push_back(cfg_row(REG_BASE_DELAY, 32'd2));
        plan.push_back(cfg_row(REG_MOD_DEPTH,  32'd0));
        plan.push_back(cfg_row(REG_MODE,       32'd1));
        plan.push_back(cfg_row(REG_FEEDBACK,   32'd64881));
        plan.push_back(cfg_row(REG_MIX,        32'd40000));
        plan.push_back(item_row(24'sh600000, 1'b0, 16'sh1234, 1'b0, '0));
        plan.push_back(item_row(24'shA00000, 1'b1, 16'shEDCB, 1'b0, '0));
        plan.push_back(item_row(24'sh333333, 1'b0, 16'sh0000, 1'b0, '0));
        plan.push_back(item_row(24'shCCCCCD, 1'b1, 16'sh0000, 1'b0, '0));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part (first item waits out the ring clear)
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                quiesce();
                reg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_item(plan[i].smp, plan[i].ch, plan[i].lfo, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiesce();

            sel = $urandom_range(9);
            if (sel < 4)       v = $urandom_range(48, 1);
            else if (sel < 6)  v = $urandom_range(4000, 1);
            else if (sel == 6) v = 262143;
            else if (sel == 7) v = 0;
            else               v = $urandom_range(262143);
            wv = $urandom;
            wv[BASE_W-1:0] = v[BASE_W-1:0];
            reg_write(REG_BASE_DELAY, wv);

            sel = $urandom_range(7);
            wv = $urandom;
            if (sel < 2)       wv[DEP_W-1:0] = '0;
            else if (sel == 2) wv[DEP_W-1:0] = '1;
            reg_write(REG_MOD_DEPTH, wv);

            sel = $urandom_range(19);
            wv = $urandom;
            if (sel < 3)       wv[GAIN_W-1:0] = '1;
            else if (sel < 5)  wv[GAIN_W-1:0] = '0;
            else if (sel < 12) wv[GAIN_W-1:0] = 16'd4096;
            reg_write(REG_INPUT_GAIN, wv);

            sel = $urandom_range(9);
            wv = $urandom;
            if (sel == 0)      wv[FB_W-1:0] = '1;
            else if (sel == 1) wv[FB_W-1:0] = 16'd64881;
            else if (sel == 2) wv[FB_W-1:0] = '0;
            reg_write(REG_FEEDBACK, wv);

            sel = $urandom_range(9);
            if (sel < 2)       v = 0;
            else if (sel < 4)  v = 65536;
            else if (sel == 4) v = $urandom_range(131071, 65537);
            else               v = $urandom_range(65536);
            wv = $urandom;
            wv[MIX_W-1:0] = v[MIX_W-1:0];
            reg_write(REG_MIX, wv);

            reg_write(REG_MODE, $urandom);
            if ($urandom_range(3) == 0) begin
                reg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end

            // One phase without idling, one with a long output hold-off
            gaps_on = (ph != 2);
            if (ph == 4) begin
                hold_req = 1'b1;
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Sender pause until the block has drained
                if (ph == 6 && k == PHASE_ITEMS / 2) begin
                    quiesce();
                end
                // Mostly alternating channel pairs, some out of order
                ch = ($urandom_range(99) < 85) ? k[0] : 1'($urandom_range(1));
                push_item(pick_sample(), ch, pick_lfo(), 1'b0, '0);
            end
        end

        quiesce();
        $display("Covered %0d items through %0d register writes: normal and ping-pong, ",
                 items_sent, reg_writes);
        $display("zero and wrapped delays, dry to fully wet; %0d outputs checked, %0d errors",
                 results_seen, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
